// ----- design/bftm_pkg.sv -----
// ----------------------------------------------------------------------------
// bftm_pkg
// Shared types and constants of the tape machine: command bytes, item
// actions, error codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package bftm_pkg;

  // Item actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  // Command bytes of the tape language
  localparam logic [7:0] CMD_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] CMD_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] CMD_OUT   = 8'h2E;  // '.'
  localparam logic [7:0] CMD_IN    = 8'h2C;  // ','
  localparam logic [7:0] CMD_INC   = 8'h2B;  // '+'
  localparam logic [7:0] CMD_DEC   = 8'h2D;  // '-'
  localparam logic [7:0] CMD_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CMD_CLOSE = 8'h5D;  // ']'

  // Value stored by ',' at end of input
  localparam logic [7:0] EOF_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    ERR_NONE           = 2'd0,
    ERR_STRAY_CLOSE    = 2'd1,
    ERR_UNMATCHED_OPEN = 2'd2,
    ERR_NEST_OVERFLOW  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    ST_CLEAR,  // tape clearing sweep
    ST_IDLE,   // waiting for an item
    ST_EXEC,   // program byte and cell available, execute
    ST_SCAN    // forward scan for the matching close bracket
  } state_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       input_taken;
    logic       waiting_input;
    logic       halted;
    err_e       error_code;
  } result_t;

endpackage

// ----- design/bftm_item_if.sv -----
// ----------------------------------------------------------------------------
// bftm_item_if
// Input channel of the tape machine: valid/ready handshake and one item.
// ----------------------------------------------------------------------------
interface bftm_item_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] code_byte;
  logic       code_last;
  logic [7:0] in_byte;
  logic       in_valid;
  logic       in_eof;

  modport source (
    output valid, action, code_byte, code_last, in_byte, in_valid, in_eof,
    input  ready
  );

  modport sink (
    input  valid, action, code_byte, code_last, in_byte, in_valid, in_eof,
    output ready
  );
endinterface

// ----- design/bftm_result_if.sv -----
// ----------------------------------------------------------------------------
// bftm_result_if
// Result channel of the tape machine: valid/ready handshake and one item.
// ----------------------------------------------------------------------------
interface bftm_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       input_taken;
  logic       waiting_input;
  logic       halted;
  logic [1:0] error_code;

  modport source (
    output valid, out_byte, out_valid, input_taken, waiting_input, halted, error_code,
    input  ready
  );

  modport sink (
    input  valid, out_byte, out_valid, input_taken, waiting_input, halted, error_code,
    output ready
  );
endinterface

// ----- design/bftm_ram.sv -----
// ----------------------------------------------------------------------------
// bftm_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module bftm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bf_tape_machine_top.sv -----
// ----------------------------------------------------------------------------
// bf_tape_machine_top
// Tape-language machine: program store, tape and loop return stack in RAMs,
// one command executed per run item.
// ----------------------------------------------------------------------------
// A run item reads the program byte, the current cell and the loop stack top
// from their RAMs in the accept cycle; the command executes and writes back
// in the next. A '[' on a zero cell then walks the program one byte per
// cycle until the matching ']' or the program end. Every item gives exactly
// one result item, held in an output register so a new item is accepted
// while the last result is being taken. After reset, all TAPE_MAX tape cells
// are swept to zero; after each final program byte the cells that were in
// use are swept, and no item is accepted during a sweep.
module bf_tape_machine_top #(
  parameter int CODE_DEPTH = 4096,
  parameter int TAPE_STEP  = 256,
  parameter int TAPE_MAX   = 4096,
  parameter int LOOP_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bftm_item_if.sink           item_i,
  bftm_result_if.source       result_o
);

  // Widths
  localparam int IPW  = $clog2(CODE_DEPTH + 1);                  // ip, length
  localparam int PAW  = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;
  localparam int CUW  = $clog2(TAPE_MAX + 1);                    // cells in use
  localparam int CPW  = (TAPE_MAX > 1) ? $clog2(TAPE_MAX) : 1;   // cell pointer
  localparam int SW   = $clog2(TAPE_MAX + TAPE_STEP + 1);        // growth sum
  localparam int DW   = $clog2(LOOP_DEPTH + 1);                  // nesting depth
  localparam int SAW  = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
  localparam int CIU_INIT = (TAPE_STEP < TAPE_MAX) ? TAPE_STEP : TAPE_MAX;

  // Machine state
  bftm_pkg::state_e  state_q, state_d;
  bftm_pkg::err_e    err_q, err_d;
  logic [IPW-1:0]    len_q, len_d;
  logic              fresh_q, fresh_d;
  logic [IPW-1:0]    ip_q, ip_d;
  logic [CPW-1:0]    cp_q, cp_d;
  logic [CUW-1:0]    ciu_q, ciu_d;
  logic [DW-1:0]     dep_q, dep_d;
  logic [CUW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [CUW-1:0]    clr_lim_q, clr_lim_d;
  logic [IPW-1:0]    scan_pos_q, scan_pos_d;
  logic [IPW-1:0]    open_q, open_d;

  // Captured input offer of the running item
  logic [7:0]        byte_in_q;
  logic              offer_q;
  logic              eof_q;

  // Result register
  logic              res_vld_q, res_vld_d;
  bftm_pkg::result_t res_q, res_d;
  logic              res_load;

  // RAM ports
  logic              prog_we, prog_re;
  logic [PAW-1:0]    prog_waddr, prog_raddr;
  logic [7:0]        prog_rdata;
  logic              tape_we, tape_re;
  logic [CPW-1:0]    tape_waddr;
  logic [7:0]        tape_wdata, tape_rdata;
  logic              stk_we, stk_re;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [IPW-1:0]    stk_rdata;

  // Helpers
  logic              accept;
  logic [IPW-1:0]    ip_p1, scan_nxt, len_base, ip_base;
  logic [CUW-1:0]    cp_inc, clr_nxt;
  logic [SW-1:0]     ciu_sum;
  logic [DW-1:0]     dep_m1;
  logic              advance;

  assign item_i.ready = (state_q == bftm_pkg::ST_IDLE) && (!res_vld_q || result_o.ready);
  assign accept       = item_i.valid && item_i.ready;

  assign ip_p1    = ip_q + IPW'(1);
  assign scan_nxt = scan_pos_q + IPW'(1);
  assign cp_inc   = CUW'(cp_q) + CUW'(1);
  assign clr_nxt  = clr_cnt_q + CUW'(1);
  assign ciu_sum  = SW'(ciu_q) + SW'(TAPE_STEP);
  assign dep_m1   = dep_q - DW'(1);
  assign len_base = fresh_q ? '0 : len_q;

  // Memories
  bftm_ram #(.WIDTH(8), .DEPTH(CODE_DEPTH)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (prog_waddr),
    .wdata_i (item_i.code_byte),
    .re_i    (prog_re),
    .raddr_i (prog_raddr),
    .rdata_o (prog_rdata)
  );

  bftm_ram #(.WIDTH(8), .DEPTH(TAPE_MAX)) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .re_i    (tape_re),
    .raddr_i (cp_q),
    .rdata_o (tape_rdata)
  );

  bftm_ram #(.WIDTH(IPW), .DEPTH(LOOP_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (ip_q),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Sequencer: next state, RAM controls and result
  always_comb begin
    state_d    = state_q;
    err_d      = err_q;
    len_d      = len_q;
    fresh_d    = fresh_q;
    ip_base    = ip_q;
    advance    = 1'b0;
    cp_d       = cp_q;
    ciu_d      = ciu_q;
    dep_d      = dep_q;
    clr_cnt_d  = clr_cnt_q;
    clr_lim_d  = clr_lim_q;
    scan_pos_d = scan_pos_q;
    open_d     = open_q;
    res_load   = 1'b0;
    res_d      = res_q;

    prog_we    = 1'b0;
    prog_waddr = len_base[PAW-1:0];
    prog_re    = 1'b0;
    prog_raddr = ip_q[PAW-1:0];
    tape_we    = 1'b0;
    tape_waddr = cp_q;
    tape_wdata = '0;
    tape_re    = 1'b0;
    stk_we     = 1'b0;
    stk_waddr  = dep_q[SAW-1:0];
    stk_re     = 1'b0;
    stk_raddr  = dep_m1[SAW-1:0];

    res_d.out_byte      = '0;
    res_d.out_valid     = 1'b0;
    res_d.input_taken   = 1'b0;
    res_d.waiting_input = 1'b0;

    unique case (state_q)
      // Sweep the tape to zero, one cell a cycle
      bftm_pkg::ST_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_cnt_q[CPW-1:0];
        clr_cnt_d  = clr_nxt;
        if (clr_nxt == clr_lim_q) begin
          state_d = bftm_pkg::ST_IDLE;
        end
      end

      bftm_pkg::ST_IDLE: begin
        if (accept) begin
          if (item_i.action == bftm_pkg::ACT_LOAD) begin
            // Append one program byte
            res_load = 1'b1;
            fresh_d  = 1'b0;
            len_d    = len_base;
            if (len_base < IPW'(CODE_DEPTH)) begin
              prog_we = 1'b1;
              len_d   = len_base + IPW'(1);
            end
            if (item_i.code_last) begin
              fresh_d   = 1'b1;
              ip_base   = '0;
              cp_d      = '0;
              ciu_d     = CUW'(CIU_INIT);
              dep_d     = '0;
              err_d     = bftm_pkg::ERR_NONE;
              clr_cnt_d = '0;
              clr_lim_d = ciu_q;
              state_d   = bftm_pkg::ST_CLEAR;
            end
          end else if (err_q != bftm_pkg::ERR_NONE || ip_q >= len_q) begin
            // Halted: report status only
            res_load = 1'b1;
          end else begin
            // Fetch command, cell and loop stack top
            prog_re = 1'b1;
            tape_re = 1'b1;
            stk_re  = 1'b1;
            state_d = bftm_pkg::ST_EXEC;
          end
        end
      end

      bftm_pkg::ST_EXEC: begin
        res_load = 1'b1;
        advance  = 1'b1;
        state_d  = bftm_pkg::ST_IDLE;
        unique case (prog_rdata)
          bftm_pkg::CMD_RIGHT: begin
            cp_d = cp_inc[CPW-1:0];
            if (cp_inc >= ciu_q) begin
              if (ciu_sum > SW'(TAPE_MAX)) begin
                cp_d = '0;
              end else begin
                ciu_d = ciu_sum[CUW-1:0];
              end
            end
          end
          bftm_pkg::CMD_LEFT: begin
            cp_d = (cp_q == '0) ? CPW'(ciu_q - CUW'(1)) : cp_q - CPW'(1);
          end
          bftm_pkg::CMD_OUT: begin
            res_d.out_byte  = tape_rdata;
            res_d.out_valid = 1'b1;
          end
          bftm_pkg::CMD_IN: begin
            if (offer_q) begin
              tape_we           = 1'b1;
              tape_wdata        = eof_q ? bftm_pkg::EOF_BYTE : byte_in_q;
              res_d.input_taken = 1'b1;
            end else begin
              res_d.waiting_input = 1'b1;
              advance             = 1'b0;
            end
          end
          bftm_pkg::CMD_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 8'd1;
          end
          bftm_pkg::CMD_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 8'd1;
          end
          bftm_pkg::CMD_OPEN: begin
            if (tape_rdata != 8'd0) begin
              if (dep_q >= DW'(LOOP_DEPTH)) begin
                err_d   = bftm_pkg::ERR_NEST_OVERFLOW;
                advance = 1'b0;
              end else begin
                stk_we = 1'b1;
                dep_d  = dep_q + DW'(1);
              end
            end else if (ip_p1 >= len_q) begin
              err_d   = bftm_pkg::ERR_UNMATCHED_OPEN;
              advance = 1'b0;
            end else begin
              // Start the forward scan at the next byte
              res_load   = 1'b0;
              advance    = 1'b0;
              prog_re    = 1'b1;
              prog_raddr = ip_p1[PAW-1:0];
              scan_pos_d = ip_p1;
              open_d     = IPW'(1);
              state_d    = bftm_pkg::ST_SCAN;
            end
          end
          bftm_pkg::CMD_CLOSE: begin
            if (dep_q == '0) begin
              err_d   = bftm_pkg::ERR_STRAY_CLOSE;
              advance = 1'b0;
            end else if (tape_rdata != 8'd0) begin
              ip_base = stk_rdata;
            end else begin
              dep_d = dep_m1;
            end
          end
          default: begin
          end
        endcase
      end

      // One program byte a cycle until the bracket count closes or the program ends
      bftm_pkg::ST_SCAN: begin
        if (prog_rdata == bftm_pkg::CMD_CLOSE && open_q == IPW'(1)) begin
          res_load = 1'b1;
          ip_base  = scan_pos_q;
          advance  = 1'b1;
          state_d  = bftm_pkg::ST_IDLE;
        end else if (scan_nxt >= len_q) begin
          res_load = 1'b1;
          err_d    = bftm_pkg::ERR_UNMATCHED_OPEN;
          state_d  = bftm_pkg::ST_IDLE;
        end else begin
          prog_re    = 1'b1;
          prog_raddr = scan_nxt[PAW-1:0];
          scan_pos_d = scan_nxt;
          if (prog_rdata == bftm_pkg::CMD_OPEN) begin
            open_d = open_q + IPW'(1);
          end else if (prog_rdata == bftm_pkg::CMD_CLOSE) begin
            open_d = open_q - IPW'(1);
          end
        end
      end

      default: begin
        state_d = bftm_pkg::ST_IDLE;
      end
    endcase

    ip_d = advance ? ip_base + IPW'(1) : ip_base;

    // Status after the step
    res_d.halted     = (err_d != bftm_pkg::ERR_NONE) || (ip_d >= len_d);
    res_d.error_code = err_d;
    res_vld_d        = res_load || (res_vld_q && !result_o.ready);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bftm_pkg::ST_CLEAR;
      err_q      <= bftm_pkg::ERR_NONE;
      len_q      <= '0;
      fresh_q    <= 1'b1;
      ip_q       <= '0;
      cp_q       <= '0;
      ciu_q      <= CUW'(CIU_INIT);
      dep_q      <= '0;
      clr_cnt_q  <= '0;
      clr_lim_q  <= CUW'(TAPE_MAX);
      scan_pos_q <= '0;
      open_q     <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      err_q      <= err_d;
      len_q      <= len_d;
      fresh_q    <= fresh_d;
      ip_q       <= ip_d;
      cp_q       <= cp_d;
      ciu_q      <= ciu_d;
      dep_q      <= dep_d;
      clr_cnt_q  <= clr_cnt_d;
      clr_lim_q  <= clr_lim_d;
      scan_pos_q <= scan_pos_d;
      open_q     <= open_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_in_q <= item_i.in_byte;
      offer_q   <= item_i.in_valid;
      eof_q     <= item_i.in_eof;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // Result channel
  assign result_o.valid         = res_vld_q;
  assign result_o.out_byte      = res_q.out_byte;
  assign result_o.out_valid     = res_q.out_valid;
  assign result_o.input_taken   = res_q.input_taken;
  assign result_o.waiting_input = res_q.waiting_input;
  assign result_o.halted        = res_q.halted;
  assign result_o.error_code    = res_q.error_code;

endmodule
